// File: rtl/xpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpc_pkg: shared types and constants
// Payload structs, register addresses and sequencer states for the cipher core.
// ----------------------------------------------------------------------------
package xpc_pkg;
    localparam int MAX_PIXELS_DEF = 4096;
    localparam int PIXEL_W = 24;
    localparam int CNT_W = 13;
    localparam int FIDX_W = 12;

    typedef enum logic [1:0] {
        REG_SEED = 2'd0,
        REG_KEY  = 2'd1,
        REG_MODE = 2'd2,
        REG_NPIX = 2'd3
    } t_reg_addr;

    typedef struct packed {
        logic       action;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [11:0] fetch_index;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       out_valid;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SH_PRNG,
        ST_SH_MOD,
        ST_SH_RD,
        ST_SH_WAIT,
        ST_SH_WR,
        ST_MV_RD,
        ST_MV_WAIT,
        ST_MV_WR,
        ST_CH_RD,
        ST_CH_WAIT,
        ST_CH_WR,
        ST_FETCH,
        ST_FETCH_OUT
    } t_state;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction
endpackage

// File: rtl/xorshift_permute_chain_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xorshift_permute_chain_cipher_core: permuting xor-chain image cipher
// Loads an rgb image, shuffles and chains it, serves result pixels by index.
// ----------------------------------------------------------------------------
// usage
//   command channel: i_start with i_cmd, taken when o_busy is low
//   action load stores one pixel; the last pixel of the image
//   starts processing, o_busy stays high until it is done
//   action fetch gives one result word on o_res with o_res_strobe, registered
//   in ST_FETCH_OUT; the receiver cannot stall, the strobe lasts one cycle
//   processing, N pixels: an init pass writes the identity permutation, then
//   each shuffle step runs an xorshift step, the serial remainder unit and
//   the memory states SH_RD, SH_WAIT, SH_WR, then a permute pass and a chain
//   pass over all pixels (chain pass first when decrypting)
//   apb port: seed 0x0, key 0x4, mode 0x8, pixel count 0xc; any write to a
//   register restarts loading and clears the processed flag
//   reset: registers to reset values, no image processed; memories are not
//   cleared, no clearing pass
// ----------------------------------------------------------------------------
module xorshift_permute_chain_cipher_core
    import xpc_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_in_word         i_cmd,
    output logic             o_busy,
    output logic             o_res_strobe,
    output t_out_word        o_res,
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic [3:0]       i_paddr,
    input  logic [31:0]      i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);
    localparam int AW = $clog2(MAX_PIXELS);
    localparam int NW = $clog2(MAX_PIXELS + 1);

    // config registers
    logic [31:0]       r_seed, r_key;
    logic              r_mode;
    logic [CNT_W-1:0]  r_npix;
    logic              w_wr;
    t_reg_addr         w_reg;

    assign o_pready = 1'b1;
    assign w_wr  = i_psel && i_penable && i_pwrite;
    assign w_reg = t_reg_addr'(i_paddr[3:2]);

    always_comb begin
        unique case (w_reg)
            REG_SEED: o_prdata = r_seed;
            REG_KEY:  o_prdata = r_key;
            REG_MODE: o_prdata = {31'd0, r_mode};
            REG_NPIX: o_prdata = {{(32-CNT_W){1'b0}}, r_npix};
            default:  o_prdata = '0;
        endcase
    end

    // effective pixel count, clamped
    logic [NW-1:0] w_n;
    always_comb begin
        if (r_npix == '0) begin
            w_n = NW'(1);
        end else if (32'(r_npix) > 32'(MAX_PIXELS)) begin
            w_n = NW'(MAX_PIXELS);
        end else begin
            w_n = NW'(r_npix);
        end
    end

    // sequencer state
    t_state           r_state, n_state;
    logic [NW-1:0]    r_i;        // loop index
    logic [NW-1:0]    r_load;
    logic             r_done;
    logic [31:0]      r_x;        // prng state
    logic [31:0]      w_xn;       // next prng word
    logic [AW-1:0]    r_j;
    logic [AW-1:0]    r_pi;       // perm[i] held
    logic [PIXEL_W-1:0] r_prev;
    logic [FIDX_W-1:0]  r_fidx;
    logic             r_fok;
    logic             r_ph;       // decrypt: 0 chain pass pending, 1 permute pass

    // memories
    logic              w_src_we, w_prm_we, w_res_we;
    logic [AW-1:0]     w_src_a, w_prm_a, w_res_a;
    logic [PIXEL_W-1:0] w_src_wd, w_res_wd, w_src_rd, w_res_rd;
    logic [AW-1:0]     w_prm_wd, w_prm_rd;

    xpc_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_PIXELS)) u_src (
        .i_clk(i_clk), .i_we(w_src_we), .i_addr(w_src_a),
        .i_wdata(w_src_wd), .o_rdata(w_src_rd));
    xpc_ram #(.WIDTH(AW), .DEPTH(MAX_PIXELS)) u_prm (
        .i_clk(i_clk), .i_we(w_prm_we), .i_addr(w_prm_a),
        .i_wdata(w_prm_wd), .o_rdata(w_prm_rd));
    xpc_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_PIXELS)) u_res (
        .i_clk(i_clk), .i_we(w_res_we), .i_addr(w_res_a),
        .i_wdata(w_res_wd), .o_rdata(w_res_rd));

    // remainder unit for the shuffle, fed the freshly stepped prng word
    logic          w_dm_start, w_dm_done;
    logic [NW-1:0] w_dm_rem;
    xpc_divmod #(.DW(NW)) u_dm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dm_start),
        .i_num(w_xn), .i_den(r_i + NW'(1)), .o_done(w_dm_done), .o_rem(w_dm_rem));

    logic w_accept, w_load, w_last;
    assign w_accept = i_start && !o_busy;
    assign w_load   = w_accept && !i_cmd.action;
    // load position after wrap rules
    logic [NW-1:0] w_lpos;
    always_comb begin
        w_lpos = (r_done || r_load >= w_n) ? '0 : r_load;
    end
    assign w_last = (w_lpos + NW'(1)) >= w_n;

    // next state
    // encrypt: shuffle, permute, chain; decrypt: shuffle, chain, permute
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_cmd.action) n_state = ST_FETCH;
                    else if (w_last) n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                if (r_i == w_n - NW'(1)) begin
                    if (w_n != NW'(1)) n_state = ST_SH_PRNG;
                    else n_state = r_mode ? ST_CH_RD : ST_MV_RD;
                end
            end
            ST_SH_PRNG: n_state = ST_SH_MOD;
            ST_SH_MOD:  if (w_dm_done) n_state = ST_SH_RD;
            ST_SH_RD:   n_state = ST_SH_WAIT;
            ST_SH_WAIT: n_state = ST_SH_WR;
            ST_SH_WR: begin
                if (r_i != NW'(1)) n_state = ST_SH_PRNG;
                else n_state = r_mode ? ST_CH_RD : ST_MV_RD;
            end
            ST_MV_RD:   n_state = ST_MV_WAIT;
            ST_MV_WAIT: n_state = ST_MV_WR;
            ST_MV_WR: begin
                if (r_i != w_n - NW'(1)) n_state = ST_MV_RD;
                else n_state = r_mode ? ST_IDLE : ST_CH_RD;
            end
            ST_CH_RD:   n_state = ST_CH_WAIT;
            ST_CH_WAIT: n_state = ST_CH_WR;
            ST_CH_WR: begin
                if (r_i != w_n - NW'(1)) n_state = ST_CH_RD;
                else n_state = (r_mode && !r_ph) ? ST_MV_RD : ST_IDLE;
            end
            ST_FETCH:   n_state = ST_FETCH_OUT;
            ST_FETCH_OUT: n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // memory control and datapath outputs
    // shuffle: SH_RD reads perm[j], WAIT writes perm[i] at j, WR perm[j] at i
    // encrypt permute: read src[i], perm[i]; write res[perm[i]]
    // decrypt permute runs after chaining: res[i] = src[perm[i]]
    assign w_xn = xorshift32(r_x);
    logic [PIXEL_W-1:0] w_cur;

    always_comb begin
        w_src_we = 1'b0; w_prm_we = 1'b0; w_res_we = 1'b0;
        w_src_a = AW'(r_i); w_prm_a = AW'(r_i); w_res_a = AW'(r_i);
        w_src_wd = {i_cmd.in_red, i_cmd.in_green, i_cmd.in_blue};
        w_prm_wd = AW'(r_i);
        w_res_wd = '0;
        w_dm_start = 1'b0;
        w_cur = '0;
        unique case (r_state)
            ST_IDLE: begin
                w_src_a  = AW'(w_lpos);
                w_src_we = w_load;
                w_res_a  = AW'(i_cmd.fetch_index);
            end
            ST_INIT: w_prm_we = 1'b1;
            ST_SH_PRNG: w_dm_start = 1'b1;
            ST_SH_MOD: w_prm_a = AW'(r_i);
            ST_SH_RD: w_prm_a = r_j;
            ST_SH_WAIT: begin
                // perm[j] now on read port; write perm[i] into j
                w_prm_a = r_j; w_prm_we = 1'b1; w_prm_wd = r_pi;
            end
            ST_SH_WR: begin
                w_prm_a = AW'(r_i); w_prm_we = 1'b1; w_prm_wd = w_prm_rd;
            end
            ST_MV_RD: begin
                // encrypt: perm[i], src[i]; decrypt (chain done first): perm[i]
            end
            ST_MV_WAIT: begin
                w_src_a = w_prm_rd;
                w_res_a = w_prm_rd;
            end
            ST_MV_WR: begin
                w_res_we = 1'b1;
                if (r_mode) begin
                    w_res_a = AW'(r_i); w_res_wd = w_src_rd;
                end else begin
                    w_res_a = r_pi; w_res_wd = r_prev;
                end
            end
            ST_CH_RD: ;
            ST_CH_WAIT: ;
            ST_CH_WR: begin
                if (r_mode) begin
                    w_cur = w_src_rd;
                    w_src_we = 1'b1;
                    w_src_wd = w_cur ^ r_prev ^ w_xn[PIXEL_W-1:0];
                end else begin
                    w_cur = w_res_rd ^ r_prev ^ w_xn[PIXEL_W-1:0];
                    w_res_we = 1'b1;
                    w_res_wd = w_cur;
                end
            end
            ST_FETCH: w_res_a = AW'(r_fidx);
            ST_FETCH_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_seed <= '0; r_key <= '0; r_mode <= 1'b0; r_npix <= CNT_W'(1);
            r_load <= '0; r_done <= 1'b0;
            o_res_strobe <= 1'b0;
            r_ph <= 1'b0;
        end else begin
            o_res_strobe <= 1'b0;
            r_state <= n_state;
            if (w_wr) begin
                unique case (w_reg)
                    REG_SEED: r_seed <= i_pwdata;
                    REG_KEY:  r_key  <= i_pwdata;
                    REG_MODE: r_mode <= i_pwdata[0];
                    REG_NPIX: r_npix <= i_pwdata[CNT_W-1:0];
                    default: ;
                endcase
                r_load <= '0; r_done <= 1'b0;
            end
            if (w_load) begin
                r_done <= 1'b0;
                r_load <= w_last ? '0 : w_lpos + NW'(1);
            end
            if (r_state == ST_INIT && n_state != ST_INIT) r_ph <= 1'b0;
            if (r_mode && r_state == ST_CH_WR && r_i == w_n - NW'(1)) r_ph <= 1'b1;
            if ((r_state == ST_CH_WR && r_i == w_n - NW'(1) && (!r_mode || r_ph)) ||
                (r_mode && r_state == ST_MV_WR && r_i == w_n - NW'(1))) begin
                r_done <= 1'b1;
            end
            if (r_state == ST_FETCH_OUT) o_res_strobe <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_i <= '0;
                r_x <= r_seed;
                r_fidx <= i_cmd.fetch_index;
                r_fok <= r_done && (NW'(i_cmd.fetch_index) < w_n);
            end
            ST_INIT: begin
                if (r_i == w_n - NW'(1)) begin
                    r_i <= (w_n == NW'(1)) ? '0 : r_i;
                    r_prev <= r_key[PIXEL_W-1:0];
                end else begin
                    r_i <= r_i + NW'(1);
                end
            end
            ST_SH_PRNG: r_x <= w_xn;
            ST_SH_MOD: begin
                if (w_dm_done) r_j <= w_dm_rem[AW-1:0];
                r_pi <= w_prm_rd;
            end
            ST_SH_RD: ;
            ST_SH_WAIT: ;
            ST_SH_WR: begin
                if (r_i == NW'(1)) r_i <= '0;
                else r_i <= r_i - NW'(1);
            end
            ST_MV_RD: ;
            ST_MV_WAIT: begin
                r_pi <= w_prm_rd;
                r_prev <= w_src_rd;
            end
            ST_MV_WR: begin
                if (r_i == w_n - NW'(1)) begin
                    r_i <= '0;
                    r_prev <= r_key[PIXEL_W-1:0];
                end else begin
                    r_i <= r_i + NW'(1);
                end
            end
            ST_CH_RD: ;
            ST_CH_WAIT: ;
            ST_CH_WR: begin
                r_x <= w_xn;
                r_prev <= r_mode ? w_cur : w_cur;
                if (r_i == w_n - NW'(1)) r_i <= '0;
                else r_i <= r_i + NW'(1);
            end
            ST_FETCH: ;
            ST_FETCH_OUT: begin
                o_res.out_red   <= r_fok ? w_res_rd[23:16] : 8'd0;
                o_res.out_green <= r_fok ? w_res_rd[15:8]  : 8'd0;
                o_res.out_blue  <= r_fok ? w_res_rd[7:0]   : 8'd0;
                o_res.out_valid <= r_fok;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    // assertions
    a_strobe_follows_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(r_state) == ST_FETCH_OUT)
        else $error("result strobe without fetch");
    a_no_valid_unprocessed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.out_valid) |-> $past(r_fok))
        else $error("valid result from unprocessed image");
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |=> !o_res_strobe)
        else $error("double strobe");
endmodule

// File: rtl/xpc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpc_ram: generic single port ram
// One access per cycle: read every cycle, written when i_we is set; registered read data.
// ----------------------------------------------------------------------------
module xpc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: rtl/xpc_divmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpc_divmod: iterative remainder unit
// Restoring remainder of a 32-bit dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module xpc_divmod #(
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [DW-1:0] o_rem
);
    logic [DW:0]   r_rem, n_rem;
    logic [31:0]   r_num;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_sh;

    assign w_sh = {r_rem[DW-1:0], r_num[31]};

    always_comb begin
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_sh - {1'b0, r_den};
        end else begin
            n_rem = w_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[30:0], 1'b0};
        end
    end

    assign o_rem = r_rem[DW-1:0];
endmodule
